FILE: rtl/pao_pkg.sv
// ----------------------------------------------------------------------------
// pao_pkg: shared types and constants
// Channel widths, depth codes and the pipeline control word used by the
// premultiplied alpha over blend.
// ----------------------------------------------------------------------------
`default_nettype none

package pao_pkg;

   localparam int CHAN_W = 16;
   localparam int LANES  = 4;
   localparam int PROD_W = 2 * CHAN_W;

   // lane order inside a pixel
   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;
   localparam int LANE_ALPHA = 3;

   // channel depth codes
   localparam logic DEPTH_8  = 1'b0;
   localparam logic DEPTH_16 = 1'b1;

   localparam logic [CHAN_W-1:0] MAX8  = 16'h00ff;
   localparam logic [CHAN_W-1:0] MAX16 = 16'hffff;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [LANES-1:0][CHAN_W-1:0] pix_type;

   // control word that travels with each item
   typedef struct packed {
      logic valid;
      logic depth;
      logic opaque;
      logic clear;
   } ctrl_type;

   // channel maximum for a depth code
   function automatic chan_type max_of(input logic depth);
      return (depth == DEPTH_16) ? MAX16 : MAX8;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pao_if.sv
// ----------------------------------------------------------------------------
// pao_if: channel interfaces
// Request, response and control register channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pao_req_if;
   import pao_pkg::*;
   logic     valid;
   logic     ready;
   chan_type upper_red;
   chan_type upper_green;
   chan_type upper_blue;
   chan_type upper_alpha;
   chan_type lower_red;
   chan_type lower_green;
   chan_type lower_blue;
   chan_type lower_alpha;

   modport source (
      output valid, upper_red, upper_green, upper_blue, upper_alpha,
             lower_red, lower_green, lower_blue, lower_alpha,
      input  ready
   );
   modport sink (
      input  valid, upper_red, upper_green, upper_blue, upper_alpha,
             lower_red, lower_green, lower_blue, lower_alpha,
      output ready
   );
endinterface

interface pao_rsp_if;
   import pao_pkg::*;
   logic     valid;
   logic     ready;
   chan_type result_red;
   chan_type result_green;
   chan_type result_blue;
   chan_type result_alpha;

   modport source (
      output valid, result_red, result_green, result_blue, result_alpha,
      input  ready
   );
   modport sink (
      input  valid, result_red, result_green, result_blue, result_alpha,
      output ready
   );
endinterface

interface pao_csr_if;
   logic valid;
   logic ready;
   logic channel_depth;

   modport source (output valid, channel_depth, input ready);
   modport sink   (input valid, channel_depth, output ready);
endinterface

`default_nettype wire

FILE: rtl/pao_lane.sv
// ----------------------------------------------------------------------------
// pao_lane: scaled product for one channel
// Computes floor(down * inv / M) with M = 2^n - 1 over three register
// stages: multiply, reciprocal estimate, remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module pao_lane (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic             depth_in,
   input  wire pao_pkg::chan_type down_in,
   input  wire pao_pkg::chan_type inv_in,
   output pao_pkg::chan_type      quot_out
);
   import pao_pkg::*;

   logic [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic              depth_a_ff;
   logic [PROD_W-1:0] prod_b_ff;
   logic              depth_b_ff;
   chan_type          q0_b_ff, q0_b_in;
   chan_type          quot_c_ff, quot_c_in;

   logic [PROD_W:0]   est_sum;
   logic [PROD_W-1:0] est_back;
   logic [PROD_W:0]   rem;

   // stage a: product
   assign prod_a_in = PROD_W'(down_in) * PROD_W'(inv_in);

   // stage b: p/(2^n-1) estimate, (p + p>>n) >> n, never above the true value
   always_comb begin
      if (depth_a_ff == DEPTH_16) begin
         est_sum = {1'b0, prod_a_ff} + (PROD_W + 1)'(prod_a_ff >> CHAN_W);
         q0_b_in = chan_type'(est_sum >> CHAN_W);
      end else begin
         est_sum = {1'b0, prod_a_ff} + (PROD_W + 1)'(prod_a_ff >> (CHAN_W / 2));
         q0_b_in = chan_type'(est_sum >> (CHAN_W / 2));
      end
   end

   // stage c: remainder p - q0*M is below 2M, so one correction step
   always_comb begin
      if (depth_b_ff == DEPTH_16) begin
         est_back = {q0_b_ff, {CHAN_W{1'b0}}};
      end else begin
         est_back = {{(CHAN_W / 2){1'b0}}, q0_b_ff, {(CHAN_W / 2){1'b0}}};
      end
      rem = {1'b0, prod_b_ff} - {1'b0, est_back} + (PROD_W + 1)'(q0_b_ff);
      if (rem >= (PROD_W + 1)'(max_of(depth_b_ff))) begin
         quot_c_in = q0_b_ff + chan_type'(1);
      end else begin
         quot_c_in = q0_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff  <= prod_a_in;
         depth_a_ff <= depth_in;
         prod_b_ff  <= prod_a_ff;
         depth_b_ff <= depth_a_ff;
         q0_b_ff    <= q0_b_in;
         quot_c_ff  <= quot_c_in;
      end
   end

   assign quot_out = quot_c_ff;

endmodule

`default_nettype wire

FILE: rtl/premultiplied_alpha_over_blend_top.sv
// ----------------------------------------------------------------------------
// premultiplied_alpha_over_blend_top: porter-duff over, premultiplied rgba
// Composites an upper pixel over a lower one, 8-bit or 16-bit channels.
//
//   channel   dir   payload                              handshake
//   req_ch    in    upper rgba, lower rgba (16b each)    valid/ready
//   rsp_ch    out   result rgba (16b each)               valid/ready
//   csr_ch    in    channel_depth (1b)                   valid/ready
//
// one item enters per cycle while the output is not stalled; the stages are input decode,
// multiply, reciprocal estimate, correction, and sum and select with the output register
// the whole pipeline holds while a result waits and rsp_ch.ready is low
// reset is synchronous and clears the valid bits and channel_depth (8-bit)
// csr writes are always taken and meant for an idle block
// ----------------------------------------------------------------------------
`default_nettype none

module premultiplied_alpha_over_blend_top (
   input wire logic   clock,
   input wire logic   reset,
   pao_req_if.sink    req_ch,
   pao_rsp_if.source  rsp_ch,
   pao_csr_if.sink    csr_ch
);
   import pao_pkg::*;

   localparam int STAGES = 4;

   logic     depth_ff;
   logic     en;

   ctrl_type ctrl_ff [1:STAGES];
   ctrl_type ctrl_in;
   pix_type  up_ff   [1:STAGES];
   pix_type  dn_ff   [1:STAGES];
   pix_type  up_in, dn_in;
   chan_type inv_ff, inv_in;
   pix_type  quot;

   logic     rsp_valid_ff;
   pix_type  res_ff, res_in;

   chan_type mask;
   logic [CHAN_W:0] sum [LANES];

   // control register
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_8;
      end else if (csr_ch.valid) begin
         depth_ff <= csr_ch.channel_depth;
      end
   end

   // global advance: hold only while the output item is not taken
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage 1: mask to depth, decode the special alpha cases
   always_comb begin
      mask = max_of(depth_ff);
      up_in[LANE_RED]   = req_ch.upper_red   & mask;
      up_in[LANE_GREEN] = req_ch.upper_green & mask;
      up_in[LANE_BLUE]  = req_ch.upper_blue  & mask;
      up_in[LANE_ALPHA] = req_ch.upper_alpha & mask;
      dn_in[LANE_RED]   = req_ch.lower_red   & mask;
      dn_in[LANE_GREEN] = req_ch.lower_green & mask;
      dn_in[LANE_BLUE]  = req_ch.lower_blue  & mask;
      dn_in[LANE_ALPHA] = req_ch.lower_alpha & mask;
      ctrl_in.valid  = req_ch.valid;
      ctrl_in.depth  = depth_ff;
      ctrl_in.opaque = (up_in[LANE_ALPHA] == mask);
      ctrl_in.clear  = (up_in[LANE_ALPHA] == '0);
      inv_in         = mask - up_in[LANE_ALPHA];
   end

   // pipeline registers, only the valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= STAGES; s++) begin
            ctrl_ff[s].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         ctrl_ff[1] <= ctrl_in;
         up_ff[1]   <= up_in;
         dn_ff[1]   <= dn_in;
         inv_ff     <= inv_in;
         for (int s = 2; s <= STAGES; s++) begin
            ctrl_ff[s] <= ctrl_ff[s-1];
            up_ff[s]   <= up_ff[s-1];
            dn_ff[s]   <= dn_ff[s-1];
         end
         rsp_valid_ff <= ctrl_ff[STAGES].valid;
         res_ff       <= res_in;
      end
   end

   // stages 2 to 4: scaled lower channel, one lane each
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      pao_lane u_lane (
         .clock    (clock),
         .en       (en),
         .depth_in (ctrl_ff[1].depth),
         .down_in  (dn_ff[1][i]),
         .inv_in   (inv_ff),
         .quot_out (quot[i])
      );
   end

   // stage 5: add, saturate colour, pick pass-through cases
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         sum[i] = {1'b0, up_ff[STAGES][i]} + {1'b0, quot[i]};
      end
      for (int i = 0; i < LANES; i++) begin
         if (i == LANE_ALPHA) begin
            res_in[i] = sum[i][CHAN_W-1:0];
         end else if (sum[i] < {1'b0, max_of(ctrl_ff[STAGES].depth)}) begin
            res_in[i] = sum[i][CHAN_W-1:0];
         end else begin
            res_in[i] = max_of(ctrl_ff[STAGES].depth);
         end
      end
      if (ctrl_ff[STAGES].opaque) begin
         res_in = up_ff[STAGES];
      end else if (ctrl_ff[STAGES].clear) begin
         res_in = dn_ff[STAGES];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_red   = res_ff[LANE_RED];
   assign rsp_ch.result_green = res_ff[LANE_GREEN];
   assign rsp_ch.result_blue  = res_ff[LANE_BLUE];
   assign rsp_ch.result_alpha = res_ff[LANE_ALPHA];

endmodule

`default_nettype wire

FILE: rtl/pao_checker.sv
// ----------------------------------------------------------------------------
// pao_checker: port-level checks for the blend top level
// Watches the channels and tracks the number of items in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pao_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire pao_pkg::pix_type  rsp_data,
   input wire logic              csr_ready
);
   import pao_pkg::*;

   localparam int DEPTH_MAX = 5;

   logic [2:0] count_ff, count_in;

   // items accepted but not yet delivered
   always_comb begin
      count_in = count_ff;
      if (req_valid && req_ready) begin
         count_in = count_in + 3'd1;
      end
      if (rsp_valid && rsp_ready) begin
         count_in = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // a waiting result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input side only stalls behind a stalled result
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // never more items in flight than pipeline stages, and no invented result
   a_inflight: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= 3'(DEPTH_MAX)) && (!rsp_valid || count_ff != 3'd0))
      else $error("item count out of range");

   // control writes are never refused
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr write refused");

endmodule

bind premultiplied_alpha_over_blend_top pao_checker u_pao_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  ({rsp_ch.result_alpha, rsp_ch.result_blue,
                rsp_ch.result_green, rsp_ch.result_red}),
   .csr_ready (csr_ch.ready)
);

`default_nettype wire

FILE: tb/sv/premultiplied_alpha_over_blend_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// premultiplied_alpha_over_blend_top_tb: over-blend compositor testbench
// Sends pixel pairs through the request channel in 8-bit and 16-bit depth,
// predicts each composited pixel in a scoreboard and compares every
// response field. Directed corner pixels come first, then shaped random
// pixels under varying sender idling and receiver stalls.
// ----------------------------------------------------------------------------

module premultiplied_alpha_over_blend_top_tb;
   import pao_pkg::*;

   localparam int CYCLE_LIMIT   = 250000;
   localparam int ITEMS_PER_SEG = 225;
   localparam int SEGMENTS      = 6;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      pix_type upper;
      pix_type lower;
   } pair_type;

   // expected composited pixels, in acceptance order
   class blend_scoreboard;
      logic        depth;
      pix_type     expected_q[$];
      int unsigned error_count;

      function new();
         depth = DEPTH_8;
         error_count = 0;
      endfunction

      function void set_depth(input logic d);
         depth = d;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // porter-duff over on premultiplied pixels at the current depth
      function pix_type composite_over(input pix_type up_in, input pix_type dn_in);
         chan_type    maxv;
         pix_type     up;
         pix_type     dn;
         pix_type     res;
         logic [31:0] inv;
         logic [31:0] sum;
         maxv = (depth == DEPTH_16) ? MAX16 : MAX8;
         for (int i = 0; i < LANES; i++) begin
            up[i] = up_in[i] & maxv;
            dn[i] = dn_in[i] & maxv;
         end
         if (up[LANE_ALPHA] == maxv) begin
            res = up;
         end else if (up[LANE_ALPHA] == '0) begin
            res = dn;
         end else begin
            inv = 32'(maxv) - 32'(up[LANE_ALPHA]);
            // colour lanes saturate at the channel maximum
            for (int i = LANE_RED; i <= LANE_BLUE; i++) begin
               sum = 32'(up[i]) + (32'(dn[i]) * inv) / 32'(maxv);
               res[i] = (sum > 32'(maxv)) ? maxv : sum[CHAN_W-1:0];
            end
            sum = 32'(up[LANE_ALPHA]) + (32'(dn[LANE_ALPHA]) * inv) / 32'(maxv);
            res[LANE_ALPHA] = sum[CHAN_W-1:0];
         end
         return res;
      endfunction

      function void note_pixel(input pair_type p);
         expected_q.push_back(composite_over(p.upper, p.lower));
      endfunction

      function void check_result(input pix_type got);
         string   field_name [LANES] =
            '{"result_red", "result_green", "result_blue", "result_alpha"};
         pix_type want;
         if (expected_q.size() == 0) begin
            $error("response item with nothing pending: %h", got);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         for (int i = 0; i < LANES; i++) begin
            if (got[i] !== want[i]) begin
               $error("%s mismatch: expected %0d, actual %0d",
                      field_name[i], want[i], got[i]);
               error_count++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   blend_scoreboard sb = new();

   pao_req_if req_ch ();
   pao_rsp_if rsp_ch ();
   pao_csr_if csr_ch ();

   premultiplied_alpha_over_blend_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stalls, ready changes on the falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= stall_pct) && !reset;
      end
   end

   // response check on every accepted item
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result({rsp_ch.result_alpha, rsp_ch.result_blue,
                          rsp_ch.result_green, rsp_ch.result_red});
      end
   end

   function automatic pair_type make_pair(input chan_type ur, ug, ub, ua,
                                          input chan_type lr, lg, lb, la);
      pair_type p;
      p.upper[LANE_RED]   = ur;
      p.upper[LANE_GREEN] = ug;
      p.upper[LANE_BLUE]  = ub;
      p.upper[LANE_ALPHA] = ua;
      p.lower[LANE_RED]   = lr;
      p.lower[LANE_GREEN] = lg;
      p.lower[LANE_BLUE]  = lb;
      p.lower[LANE_ALPHA] = la;
      return p;
   endfunction

   // in 8-bit mode the upper byte is don't-care, so fill it at random half the time
   function automatic chan_type dress_field(input logic depth, input chan_type v);
      if (depth == DEPTH_8 && $urandom_range(1)) begin
         return {8'($urandom()), v[7:0]};
      end
      return v;
   endfunction

   // one pixel: alpha biased toward the opaque, clear and near-edge cases,
   // colour mostly premultiplied (at most alpha), otherwise anything
   function automatic void random_pixel(input logic depth, output pix_type px);
      chan_type maxv;
      chan_type a;
      int unsigned sel;
      maxv = (depth == DEPTH_16) ? MAX16 : MAX8;
      sel = $urandom_range(99);
      if (sel < 15)      a = maxv;
      else if (sel < 30) a = '0;
      else if (sel < 35) a = chan_type'(1);
      else if (sel < 40) a = maxv - chan_type'(1);
      else               a = chan_type'($urandom_range(32'(maxv)));
      for (int i = LANE_RED; i <= LANE_BLUE; i++) begin
         if ($urandom_range(99) < 65) begin
            px[i] = dress_field(depth, chan_type'($urandom_range(32'(a))));
         end else begin
            px[i] = dress_field(depth, chan_type'($urandom_range(32'(maxv))));
         end
      end
      px[LANE_ALPHA] = dress_field(depth, a);
   endfunction

   function automatic pair_type make_random_pair(input logic depth);
      pair_type p;
      random_pixel(depth, p.upper);
      random_pixel(depth, p.lower);
      return p;
   endfunction

   // entered and left on a falling edge; valid stays high for back-to-back items
   task automatic send_pixel(input pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.upper_red   = p.upper[LANE_RED];
      req_ch.upper_green = p.upper[LANE_GREEN];
      req_ch.upper_blue  = p.upper[LANE_BLUE];
      req_ch.upper_alpha = p.upper[LANE_ALPHA];
      req_ch.lower_red   = p.lower[LANE_RED];
      req_ch.lower_green = p.lower[LANE_GREEN];
      req_ch.lower_blue  = p.lower[LANE_BLUE];
      req_ch.lower_alpha = p.lower[LANE_ALPHA];
      do @(posedge clock); while (!req_ch.ready);
      sb.note_pixel(p);
      @(negedge clock);
   endtask

   // sender holds off until every pending pixel has come back
   task automatic drain_pipeline();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_depth(input logic d);
      csr_ch.valid         = 1'b1;
      csr_ch.channel_depth = d;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_depth(d);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // corner pixels for one depth
   task automatic send_corners(input logic depth);
      chan_type m;
      m = (depth == DEPTH_16) ? MAX16 : MAX8;
      send_pixel(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_pair(m, m, m, m, m, m, m, m));
      send_pixel(make_pair(10, 20, 30, m, m, 1, m / 2, m));
      send_pixel(make_pair(5, 6, 7, 0, m, 1, m / 2, m));
      send_pixel(make_pair(1, 1, 0, 1, m, m, m, m));
      send_pixel(make_pair(m - 1, 0, m - 1, m - 1, m, m, 0, m));
      // colour above alpha, sum clips at the maximum
      send_pixel(make_pair(m, m, m, m / 2, m, m, m, m));
      send_pixel(make_pair(m / 4, m / 3, m / 5, m / 2, m / 2, m / 3, m, m / 2));
      if (depth == DEPTH_16) begin
         // alpha values that only look special in the low byte
         send_pixel(make_pair(16'h00ff, 16'h0080, 16'h0001, 16'h00ff,
                              16'hffff, 16'h8000, 16'h1234, 16'hffff));
         send_pixel(make_pair(16'hff00, 16'h0100, 16'h7fff, 16'hff00,
                              16'hffff, 16'hffff, 16'hffff, 16'hfffe));
      end else begin
         // upper byte ignored: clear alpha and opaque alpha by low byte
         send_pixel(make_pair(16'hff40, 16'hff00, 16'h8001, 16'h7f00,
                              16'hffc0, 16'h55aa, 16'haa55, 16'hff7f));
         send_pixel(make_pair(16'hffff, 16'hff10, 16'h0180, 16'h12ff,
                              16'hffff, 16'hffff, 16'hffff, 16'hffff));
      end
   endtask

   // main sequence
   initial begin
      logic seg_depth;
      reset                = 1'b1;
      cycle_count          = 0;
      send_idle_pct        = 18;
      stall_pct            = 56;
      req_ch.valid         = 1'b0;
      req_ch.upper_red     = '0;
      req_ch.upper_green   = '0;
      req_ch.upper_blue    = '0;
      req_ch.upper_alpha   = '0;
      req_ch.lower_red     = '0;
      req_ch.lower_green   = '0;
      req_ch.lower_blue    = '0;
      req_ch.lower_alpha   = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.channel_depth = DEPTH_8;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed corners at both depths
      write_depth(DEPTH_16);
      send_corners(DEPTH_16);
      drain_pipeline();
      write_depth(DEPTH_8);
      send_corners(DEPTH_8);

      // random segments: two per idling pattern, depth alternating
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_pipeline();
         if (seg < 2) begin
            send_idle_pct = 18;
            stall_pct     = 56;
         end else if (seg < 4) begin
            send_idle_pct = 56;
            stall_pct     = 18;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         seg_depth = (seg % 2 == 0) ? DEPTH_16 : DEPTH_8;
         write_depth(seg_depth);
         for (int n = 0; n < ITEMS_PER_SEG; n++) begin
            send_pixel(make_random_pair(seg_depth));
         end
      end

      // wait out the last responses
      drain_pipeline();
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
